// ===== hdl/mctb_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer bank package
// Shared sizes, payload and command types, and conversion helpers for the
// multi-channel timer bank.
// ----------------------------------------------------------------------------
package mctb_pkg;

    localparam int CHANNELS    = 10;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int ACTION_W = 2;
    localparam int CHAN_W   = 4;
    localparam int VALUE_W  = 16;
    localparam int MASK_W   = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_SPARE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_START,
        CMD_STOP,
        CMD_NOP
    } t_cmd_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_APPLY
    } t_back_state;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAN_W-1:0]   channel;
        logic [VALUE_W-1:0]  reload_value;
        logic                periodic;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] expired_mask;
        logic [CHAN_W-1:0] assigned_channel;
        logic              bank_full;
    } t_out_item;

    typedef struct packed {
        t_cmd_op                op;
        logic [IDX_W-1:0]       chan;
        logic [COUNT_WIDTH-1:0] value;
        logic                   periodic;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic avail;
    } t_queue_status;

    function automatic logic chan_in_range(input logic [CHAN_W-1:0] c);
        return 32'(c) < 32'(CHANNELS);
    endfunction

    function automatic logic [IDX_W-1:0] chan_to_idx(input logic [CHAN_W-1:0] c);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < IDX_W && i < CHAN_W; i++) r[i] = c[i];
        return r;
    endfunction

    function automatic logic [CHAN_W-1:0] idx_to_chan(input logic [IDX_W-1:0] x);
        logic [CHAN_W-1:0] r;
        r = '0;
        for (int i = 0; i < IDX_W && i < CHAN_W; i++) r[i] = x[i];
        return r;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] value_to_count(input logic [VALUE_W-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        r = '0;
        for (int i = 0; i < COUNT_WIDTH && i < VALUE_W; i++) r[i] = v[i];
        return r;
    endfunction

    function automatic logic [MASK_W-1:0] fired_to_mask(input logic [CHANNELS-1:0] f);
        logic [MASK_W-1:0] r;
        r = '0;
        for (int i = 0; i < MASK_W && i < CHANNELS; i++) r[i] = f[i];
        return r;
    endfunction

endpackage

// ===== hdl/mctb_front.sv =====
// ----------------------------------------------------------------------------
// Timer bank front end
// Decodes an incoming request into a command for the channel engine.
// ----------------------------------------------------------------------------
module mctb_front import mctb_pkg::*; (
    input  t_in_item i_item,
    output t_cmd     o_cmd
);

    always_comb begin
        o_cmd.chan     = chan_to_idx(i_item.channel);
        o_cmd.value    = value_to_count(i_item.reload_value);
        o_cmd.periodic = i_item.periodic;
        case (t_action'(i_item.action))
            ACT_TICK:  o_cmd.op = CMD_TICK;
            ACT_START: o_cmd.op = CMD_START;
            // A stop aimed beyond the last channel has no effect.
            ACT_STOP:  o_cmd.op = chan_in_range(i_item.channel) ? CMD_STOP : CMD_NOP;
            default:   o_cmd.op = CMD_NOP;
        endcase
    end

endmodule

// ===== hdl/mctb_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// Timer bank command queue
// Short first-in first-out buffer between the front end and the engine.
// ----------------------------------------------------------------------------
module mctb_cmd_queue import mctb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_cmd,
    input  logic          i_pop,
    output t_cmd          o_cmd,
    output t_queue_status o_status
);

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              w_do_push, w_do_pop;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.avail = (r_count != '0);
    assign o_cmd          = r_mem[r_rd_ptr];

    assign w_do_push = i_push && !o_status.full;
    assign w_do_pop  = i_pop && o_status.avail;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hdl/mctb_back.sv =====
// ----------------------------------------------------------------------------
// Timer bank channel engine
// Holds the channel state, walks the channels on a tick, claims or releases
// channels, and keeps the finished result in an output register.
// ----------------------------------------------------------------------------
module mctb_back import mctb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  t_queue_status i_queue,
    output logic          o_cmd_pop,
    output t_out_item     o_result,
    output logic          o_empty,
    input  logic          i_pop
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    t_back_state            r_state, n_state;
    t_cmd                   r_cmd;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CHANNELS-1:0]    r_fired, n_fired;
    logic [CHANNELS-1:0]    r_running, n_running;
    logic                   r_repeat    [CHANNELS];
    logic [COUNT_WIDTH-1:0] r_remaining [CHANNELS];
    logic [COUNT_WIDTH-1:0] r_reload    [CHANNELS];
    t_out_item              r_out, n_out;
    logic                   r_out_valid, n_out_valid;

    logic                   w_slot_free;
    logic                   w_take, w_walk, w_apply, w_finish;
    logic                   w_cur_run, w_cur_fire;
    logic [COUNT_WIDTH-1:0] w_cur_rem;
    logic                   w_free_found;
    logic [IDX_W-1:0]       w_free_idx;
    logic                   w_claim;

    assign w_slot_free = !r_out_valid || i_pop;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_queue.avail && w_slot_free) begin
                    n_state = (i_cmd.op == CMD_TICK) ? ST_WALK : ST_APPLY;
                end
            end
            ST_WALK: begin
                if (r_idx == LAST_IDX) n_state = ST_IDLE;
            end
            ST_APPLY: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State decoding.
    always_comb begin
        w_take  = 1'b0;
        w_walk  = 1'b0;
        w_apply = 1'b0;
        case (r_state)
            ST_IDLE:  w_take  = i_queue.avail && w_slot_free;
            ST_WALK:  w_walk  = 1'b1;
            ST_APPLY: w_apply = 1'b1;
            default:  w_take  = 1'b0;
        endcase
    end

    assign o_cmd_pop = w_take;
    assign w_finish  = (w_walk && (r_idx == LAST_IDX)) || w_apply;

    assign w_cur_run  = r_running[r_idx];
    assign w_cur_rem  = r_remaining[r_idx];
    assign w_cur_fire = w_walk && w_cur_run && (w_cur_rem == '0);

    // Lowest channel that is not running.
    always_comb begin
        w_free_found = 1'b0;
        w_free_idx   = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (!r_running[i]) begin
                w_free_found = 1'b1;
                w_free_idx   = IDX_W'(i);
            end
        end
    end

    assign w_claim = w_apply && (r_cmd.op == CMD_START) && w_free_found;

    always_comb begin
        n_running = r_running;
        n_fired   = r_fired;
        n_idx     = r_idx;
        if (w_take) begin
            n_fired = '0;
            n_idx   = '0;
        end
        if (w_walk) begin
            n_idx = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            if (w_cur_fire) begin
                n_fired[r_idx] = 1'b1;
                if (!r_repeat[r_idx]) n_running[r_idx] = 1'b0;
            end
        end
        if (w_claim) begin
            n_running[w_free_idx] = 1'b1;
        end
        if (w_apply && (r_cmd.op == CMD_STOP)) begin
            n_running[r_cmd.chan] = 1'b0;
        end
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_pop) n_out_valid = 1'b0;
        if (w_finish) begin
            n_out_valid = 1'b1;
            n_out       = '0;
            case (r_cmd.op)
                CMD_TICK:  n_out.expired_mask = fired_to_mask(n_fired);
                CMD_START: begin
                    if (w_free_found) begin
                        n_out.assigned_channel = idx_to_chan(w_free_idx);
                    end else begin
                        n_out.bank_full = 1'b1;
                    end
                end
                default:   n_out = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_running   <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fired <= n_fired;
        r_out   <= n_out;
        if (w_take) begin
            r_cmd <= i_cmd;
        end
        if (w_walk && w_cur_run) begin
            if (w_cur_rem != '0) begin
                r_remaining[r_idx] <= w_cur_rem - 1'b1;
            end else if (r_repeat[r_idx]) begin
                r_remaining[r_idx] <= r_reload[r_idx];
            end
        end
        if (w_claim) begin
            r_remaining[w_free_idx] <= r_cmd.value;
            r_reload[w_free_idx]    <= r_cmd.value;
            r_repeat[w_free_idx]    <= r_cmd.periodic;
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

    a_walk_is_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_cmd.op == CMD_TICK))
        else $error("channel walk running for a command other than tick");

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd_pop)
        else $error("command taken while the engine is busy");

    a_claim_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_claim |=> r_running[$past(w_free_idx)])
        else $error("claimed channel is not running after a start");

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (!r_out_valid || i_pop))
        else $error("command taken while an unread result would be overwritten");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_idx <= LAST_IDX))
        else $error("channel walk index beyond the last channel");

endmodule

// ===== hdl/multi_channel_timer_bank.sv =====
// A request is written into the command queue at the accepting edge; the engine
// takes it once idle with its result register empty or being read. A tick walks
// every channel, one channel per cycle, and registers its result after the last;
// a start, a stop or an unused action goes through the apply state. The queue
// takes requests while the engine is busy, until full. Synchronous active-low reset
// stops every channel and empties the queue and the result register.
// ----------------------------------------------------------------------------
// Multi-channel timer bank
// Front end decodes requests into a short command queue; the channel engine
// executes them and presents one result per request.
// ----------------------------------------------------------------------------
module multi_channel_timer_bank import mctb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    t_cmd          w_front_cmd;
    t_cmd          w_queue_cmd;
    t_queue_status w_queue_status;
    logic          w_cmd_pop;

    mctb_front u_front (
        .i_item (i_item),
        .o_cmd  (w_front_cmd)
    );

    mctb_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (w_front_cmd),
        .i_pop    (w_cmd_pop),
        .o_cmd    (w_queue_cmd),
        .o_status (w_queue_status)
    );

    mctb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_queue_cmd),
        .i_queue   (w_queue_status),
        .o_cmd_pop (w_cmd_pop),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    assign full = w_queue_status.full;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Timer bank testbench
// Sends tick, start and stop requests through the push/full queue interface
// and checks every result taken off the pop/empty side against a cycle-free
// model of the channel table or a typed row's result. A short directed table
// leads, then random traffic in phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import mctb_pkg::*;

    localparam int RANDOM_REQUESTS = 360;
    localparam int N_DIRECTED      = 24;
    localparam int REPORT_LIMIT    = 10;
    localparam int DRAIN_CYCLES    = 40;

    localparam t_out_item ZERO_RESULT = '0;

    typedef struct packed {
        t_in_item  req;
        logic      typed;
        t_out_item want;
    } t_stim_row;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_result;

    // Model copy of the channel table.
    logic                   chan_running  [CHANNELS];
    logic                   chan_periodic [CHANNELS];
    logic [COUNT_WIDTH-1:0] chan_count    [CHANNELS];
    logic [COUNT_WIDTH-1:0] chan_reload   [CHANNELS];

    t_out_item expected_results [$];
    int        error_count    = 0;
    int        send_idle_pct  = 0;
    int        pop_stall_pct  = 0;

    // Rows with typed set carry a result that can be read straight off the
    // behaviour; the rest are checked against the model.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{'{ACT_TICK,  4'd0,  16'h0000, 1'b0}, 1'b1, '{10'd0, 4'd0, 1'b0}},
        '{'{ACT_STOP,  4'd0,  16'h0000, 1'b0}, 1'b1, '{10'd0, 4'd0, 1'b0}},
        '{'{ACT_SPARE, 4'd15, 16'hFFFF, 1'b1}, 1'b1, '{10'd0, 4'd0, 1'b0}},
        '{'{ACT_START, 4'd0,  16'h0000, 1'b0}, 1'b1, '{10'd0, 4'd0, 1'b0}},
        '{'{ACT_START, 4'd15, 16'hFFFF, 1'b1}, 1'b1, '{10'd0, 4'd1, 1'b0}},
        '{'{ACT_START, 4'd0,  16'h0001, 1'b1}, 1'b1, '{10'd0, 4'd2, 1'b0}},
        '{'{ACT_TICK,  4'd9,  16'h1234, 1'b1}, 1'b0, ZERO_RESULT},
        '{'{ACT_TICK,  4'd0,  16'h0000, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_START, 4'd0,  16'h0002, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_START, 4'd5,  16'h0003, 1'b1}, 1'b0, ZERO_RESULT},
        '{'{ACT_START, 4'd0,  16'h0000, 1'b1}, 1'b0, ZERO_RESULT},
        '{'{ACT_START, 4'd10, 16'h0005, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_START, 4'd0,  16'h5A5A, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_START, 4'd15, 16'hA5A5, 1'b1}, 1'b0, ZERO_RESULT},
        '{'{ACT_START, 4'd0,  16'h0004, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_START, 4'd0,  16'h0000, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_START, 4'd0,  16'h0007, 1'b1}, 1'b1, '{10'd0, 4'd0, 1'b1}},
        '{'{ACT_STOP,  4'd15, 16'h0000, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_STOP,  4'd10, 16'hFFFF, 1'b1}, 1'b0, ZERO_RESULT},
        '{'{ACT_STOP,  4'd9,  16'h0000, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_TICK,  4'd0,  16'h0000, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_TICK,  4'd0,  16'h0000, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_START, 4'd0,  16'h0003, 1'b0}, 1'b0, ZERO_RESULT},
        '{'{ACT_TICK,  4'd0,  16'h0000, 1'b0}, 1'b0, ZERO_RESULT}
    };

    multi_channel_timer_bank dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Applies one request to the model table and returns the result it gives.
    function automatic t_out_item predict_timer_result(input t_in_item req);
        t_out_item        res;
        logic [MASK_W-1:0] fired;
        logic             claimed;
        res     = '0;
        fired   = '0;
        claimed = 1'b0;
        case (t_action'(req.action))
            ACT_TICK: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (chan_running[i]) begin
                        if (chan_count[i] != '0) begin
                            chan_count[i] = chan_count[i] - 1'b1;
                        end else begin
                            if (i < MASK_W) fired[i] = 1'b1;
                            if (chan_periodic[i]) chan_count[i] = chan_reload[i];
                            else chan_running[i] = 1'b0;
                        end
                    end
                end
                res.expired_mask = fired;
            end
            ACT_START: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (!claimed && !chan_running[i]) begin
                        chan_count[i]         = COUNT_WIDTH'(req.reload_value);
                        chan_reload[i]        = COUNT_WIDTH'(req.reload_value);
                        chan_periodic[i]      = req.periodic;
                        chan_running[i]       = 1'b1;
                        res.assigned_channel  = CHAN_W'(i);
                        claimed               = 1'b1;
                    end
                end
                res.bank_full = !claimed;
            end
            ACT_STOP: begin
                if (int'(req.channel) < CHANNELS) chan_running[req.channel] = 1'b0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_in_item random_request();
        t_in_item req;
        int       roll;
        roll             = $urandom_range(99);
        req.channel      = CHAN_W'($urandom_range(15));
        req.reload_value = VALUE_W'($urandom);
        req.periodic     = 1'($urandom_range(1));
        if (roll < 50) begin
            req.action = ACT_TICK;
        end else if (roll < 75) begin
            req.action = ACT_START;
            // Short counts keep channels firing and freeing up.
            if ($urandom_range(9) < 8) req.reload_value = VALUE_W'($urandom_range(7));
        end else if (roll < 95) begin
            req.action = ACT_STOP;
            if ($urandom_range(9) < 8) req.channel = CHAN_W'($urandom_range(CHANNELS - 1));
        end else begin
            req.action = ACT_SPARE;
        end
        return req;
    endfunction

    task automatic send_request(input t_in_item req, input logic typed,
                                input t_out_item want);
        t_out_item predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= req;
        do @(posedge i_clk); while (full);
        predicted = predict_timer_result(req);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic check_result(input t_out_item actual);
        t_out_item want;
        if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
                $display("Unexpected result: mask=%h chan=%0d full=%b",
                         actual.expired_mask, actual.assigned_channel, actual.bank_full);
        end else begin
            want = expected_results.pop_front();
            if (actual.expired_mask !== want.expired_mask
                    || actual.assigned_channel !== want.assigned_channel
                    || actual.bank_full !== want.bank_full) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("Mismatch: expected mask=%h chan=%0d full=%b, got mask=%h chan=%0d full=%b",
                             want.expired_mask, want.assigned_channel, want.bank_full,
                             actual.expired_mask, actual.assigned_channel, actual.bank_full);
            end
        end
    endtask

    // Result side: take a result at each edge where pop and not empty held.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) check_result(o_result);
            pop <= ($urandom_range(99) >= pop_stall_pct);
        end
    end

    initial begin
        t_in_item req;
        int       useful;
        for (int i = 0; i < CHANNELS; i++) begin
            chan_running[i]  = 1'b0;
            chan_periodic[i] = 1'b0;
            chan_count[i]    = '0;
            chan_reload[i]   = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++)
            send_request(directed_rows[r].req, directed_rows[r].typed,
                         directed_rows[r].want);

        // Ignored requests (spare action, stop out of range) do not count.
        useful = 0;
        while (useful < RANDOM_REQUESTS) begin
            case (useful * 4 / RANDOM_REQUESTS)
                0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
                1: begin send_idle_pct = 62; pop_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  pop_stall_pct = 62; end
                default: begin send_idle_pct = 28; pop_stall_pct = 28; end
            endcase
            req = random_request();
            send_request(req, 1'b0, ZERO_RESULT);
            if (!(req.action == ACT_SPARE
                    || (req.action == ACT_STOP && int'(req.channel) >= CHANNELS)))
                useful++;
        end
        push <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mctb_pkg.sv
hdl/mctb_front.sv
hdl/mctb_cmd_queue.sv
hdl/mctb_back.sv
hdl/multi_channel_timer_bank.sv
tb/tb_top.sv
